// File: hw/rtl/rlft_pkg.sv
package rlft_pkg;

    localparam int CNT_BITS = 16;
    localparam int RMS_BITS = 16;
    localparam int MIN_BITS = 17;

    localparam logic [CNT_BITS-1:0] BLOCK_LENGTH_RESET = 16'd10000;
    localparam logic [MIN_BITS-1:0] MIN_RMS_NONE       = 17'h1FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_DONE
    } t_back_state;

endpackage

// File: hw/rtl/rlft_queue.sv
module rlft_queue #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy exceeds its depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("block pushed into a full queue");

endmodule

// File: hw/rtl/rlft_front.sv
module rlft_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 2 * SAMPLE_BITS + 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [15:0]                    i_sample,
    output logic                           o_full,
    input  logic [rlft_pkg::CNT_BITS-1:0]  i_block_length,
    output logic                           o_blk_push,
    output logic [SUM_W-1:0]               o_blk_sum,
    output logic [rlft_pkg::CNT_BITS-1:0]  o_blk_count,
    input  logic                           i_blk_full
);
    import rlft_pkg::*;

    logic [SAMPLE_BITS-1:0]   raw;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [SAMPLE_BITS-1:0]   r_mag;
    logic                     r_mag_vld;
    logic [2*SAMPLE_BITS-1:0] r_sq;
    logic                     r_sq_vld;
    logic [SUM_W-1:0]         r_sum;
    logic [CNT_BITS-1:0]      r_count;
    logic [SUM_W-1:0]         sum_next;
    logic [CNT_BITS:0]        count_next;
    logic [CNT_BITS:0]        len;
    logic                     blk_end;
    logic                     acc_go;
    logic                     sq_free;
    logic                     accept;

    if (SAMPLE_BITS <= 16) begin : g_narrow
        assign raw = i_sample[SAMPLE_BITS-1:0];
    end else begin : g_wide
        assign raw = SAMPLE_BITS'(i_sample);
    end

    // The most negative code negates onto itself, which is its exact magnitude.
    assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

    assign len        = (i_block_length == '0) ? (CNT_BITS+1)'(1) : {1'b0, i_block_length};
    assign count_next = {1'b0, r_count} + 1'b1;
    assign sum_next   = r_sum + SUM_W'(r_sq);
    assign blk_end    = (count_next >= len);
    assign acc_go     = r_sq_vld && (!blk_end || !i_blk_full);
    assign sq_free    = !r_sq_vld || acc_go;
    assign o_full     = r_mag_vld && !sq_free;
    assign accept     = i_push && !o_full;

    assign o_blk_push  = acc_go && blk_end;
    assign o_blk_sum   = sum_next;
    assign o_blk_count = count_next[CNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_vld <= 1'b0;
            r_sq_vld  <= 1'b0;
            r_sum     <= '0;
            r_count   <= '0;
        end else begin
            if (!r_mag_vld || sq_free) begin
                r_mag_vld <= accept;
            end
            if (sq_free) begin
                r_sq_vld <= r_mag_vld;
            end
            if (acc_go) begin
                if (blk_end) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= sum_next;
                    r_count <= count_next[CNT_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag <= mag;
        end
        if (sq_free && r_mag_vld) begin
            r_sq <= r_mag * r_mag;
        end
    end

endmodule

// File: hw/rtl/rlft_back.sv
module rlft_back #(
    parameter int SUM_W = 46
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_blk_empty,
    output logic                           o_blk_pop,
    input  logic [SUM_W-1:0]               i_blk_sum,
    input  logic [rlft_pkg::CNT_BITS-1:0]  i_blk_count,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [rlft_pkg::RMS_BITS-1:0]  o_level,
    output logic [rlft_pkg::RMS_BITS-1:0]  o_block_rms,
    output logic [rlft_pkg::RMS_BITS-1:0]  o_noise_floor
);
    import rlft_pkg::*;

    localparam int RT_W   = SUM_W / 2;
    localparam int STEP_W = $clog2(SUM_W);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [SUM_W-1:0]     r_work;
    logic [SUM_W-1:0]     n_work;
    logic [CNT_BITS-1:0]  r_divisor;
    logic [CNT_BITS-1:0]  r_rem;
    logic [CNT_BITS-1:0]  n_rem;
    logic [RT_W+1:0]      r_srem;
    logic [RT_W+1:0]      n_srem;
    logic [RT_W-1:0]      r_root;
    logic [RT_W-1:0]      n_root;
    logic [STEP_W-1:0]    r_step;
    logic [STEP_W-1:0]    n_step;
    logic                 r_out_vld;
    logic                 n_out_vld;
    logic [MIN_BITS-1:0]  r_min;
    logic [MIN_BITS-1:0]  n_min;
    logic [RMS_BITS-1:0]  r_level;
    logic [RMS_BITS-1:0]  r_rms;
    logic [RMS_BITS-1:0]  r_floor;
    logic                 finish;

    logic [CNT_BITS:0]    div_sh;
    logic [CNT_BITS:0]    div_ext;
    logic                 div_ge;
    logic [RT_W+3:0]      rt_sh;
    logic [RT_W+3:0]      rt_trial;
    logic                 rt_ge;
    logic [RMS_BITS-1:0]  rms;
    logic [MIN_BITS-1:0]  min_cand;

    // Restoring division: one quotient bit per cycle, shifted into r_work.
    assign div_sh  = {r_rem, r_work[SUM_W-1]};
    assign div_ext = {1'b0, r_divisor};
    assign div_ge  = (div_sh >= div_ext);

    // Digit-by-digit square root: two radicand bits in, one root bit out per cycle.
    assign rt_sh    = {r_srem, r_work[SUM_W-1 -: 2]};
    assign rt_trial = (RT_W+4)'({r_root, 2'b01});
    assign rt_ge    = (rt_sh >= rt_trial);

    if (RT_W > RMS_BITS) begin : g_sat
        assign rms = (|r_root[RT_W-1:RMS_BITS]) ? '1 : r_root[RMS_BITS-1:0];
    end else begin : g_ext
        assign rms = RMS_BITS'(r_root);
    end

    assign min_cand = ({1'b0, rms} < r_min) ? {1'b0, rms} : r_min;

    always_comb begin
        n_state   = r_state;
        n_work    = r_work;
        n_rem     = r_rem;
        n_srem    = r_srem;
        n_root    = r_root;
        n_step    = r_step;
        n_min     = r_min;
        n_out_vld = r_out_vld && !i_pop;
        o_blk_pop = 1'b0;
        finish    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_blk_empty) begin
                    o_blk_pop = 1'b1;
                    n_work    = i_blk_sum;
                    n_rem     = '0;
                    n_step    = STEP_W'(SUM_W - 1);
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                n_work = {r_work[SUM_W-2:0], div_ge};
                n_rem  = div_ge ? CNT_BITS'(div_sh - div_ext) : div_sh[CNT_BITS-1:0];
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_srem  = '0;
                    n_root  = '0;
                    n_step  = STEP_W'(RT_W - 1);
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                n_work = {r_work[SUM_W-3:0], 2'b00};
                n_srem = rt_ge ? (RT_W+2)'(rt_sh - rt_trial) : rt_sh[RT_W+1:0];
                n_root = {r_root[RT_W-2:0], rt_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_pop) begin
                    finish    = 1'b1;
                    n_min     = min_cand;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_min     <= MIN_RMS_NONE;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_min     <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work    <= n_work;
        r_rem     <= n_rem;
        r_srem    <= n_srem;
        r_root    <= n_root;
        r_step    <= n_step;
        if (o_blk_pop) begin
            r_divisor <= i_blk_count;
        end
        if (finish) begin
            r_rms   <= rms;
            r_floor <= min_cand[RMS_BITS-1:0];
            r_level <= rms - min_cand[RMS_BITS-1:0];
        end
    end

    assign o_empty       = !r_out_vld;
    assign o_level       = r_level;
    assign o_block_rms   = r_rms;
    assign o_noise_floor = r_floor;

endmodule

// File: hw/rtl/rms_level_floor_tracker_top.sv
// Block RMS level meter with a tracked noise floor.
//
// Samples enter through a queue-style port: a transaction happens when push
// is high and full is low. Each sample is squared and summed; after
// block_length samples (zero acts as one) one result is queued on the output
// side. Results are read through empty/pop: the oldest result is on the ports
// while empty is low and leaves on a clock edge with pop high.
// block_length is written over the cfg valid/ready channel, which is always
// ready; write it only while the block is idle.
//
// The sample pipeline (magnitude, square, accumulate) accepts one sample per
// cycle while full is low and hands a block sum to a two-entry queue after its
// last sample has passed the magnitude and square registers. The back end pops
// it when idle, divides by the sample count one quotient bit at a time, takes
// the root two radicand bits at a time and registers the result. It takes a new
// block sum only after that result is registered, so the back end limits the
// throughput when blocks are short.
// When the reader stalls, the finished result waits in the output register,
// the back end holds its next result, the queue fills, and then full rises.
// Synchronous reset clears the control state: block_length to 10000, no noise floor.
module rms_level_floor_tracker_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_sample,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_level,
    output logic [15:0] o_block_rms,
    output logic [15:0] o_noise_floor,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import rlft_pkg::*;

    localparam int SUM_W  = 2 * SAMPLE_BITS + 14;
    localparam int LINK_W = SUM_W + CNT_BITS;

    logic [CNT_BITS-1:0] r_block_length;
    logic                blk_push;
    logic [SUM_W-1:0]    blk_sum;
    logic [CNT_BITS-1:0] blk_count;
    logic                blk_full;
    logic                blk_empty;
    logic                blk_pop;
    logic [LINK_W-1:0]   link_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_block_length <= i_cfg_data;
        end
    end

    rlft_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_sample       (i_sample),
        .o_full         (full),
        .i_block_length (r_block_length),
        .o_blk_push     (blk_push),
        .o_blk_sum      (blk_sum),
        .o_blk_count    (blk_count),
        .i_blk_full     (blk_full)
    );

    rlft_queue #(
        .WIDTH (LINK_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (blk_push),
        .i_data  ({blk_sum, blk_count}),
        .o_full  (blk_full),
        .i_pop   (blk_pop),
        .o_data  (link_out),
        .o_empty (blk_empty)
    );

    rlft_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_blk_empty   (blk_empty),
        .o_blk_pop     (blk_pop),
        .i_blk_sum     (link_out[LINK_W-1:CNT_BITS]),
        .i_blk_count   (link_out[CNT_BITS-1:0]),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_level       (o_level),
        .o_block_rms   (o_block_rms),
        .o_noise_floor (o_noise_floor)
    );

    a_floor_below_rms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_noise_floor <= o_block_rms))
        else $error("noise floor above block RMS");

    a_level_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_level == 16'(o_block_rms - o_noise_floor)))
        else $error("level does not match RMS minus floor");

endmodule

// File: test/tb_rms_level_floor_tracker_top.sv
`timescale 1ns / 1ps

module tb_rms_level_floor_tracker_top;
    import rlft_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int PREFIX_ITEMS  = 100;
    localparam int PROBE_COUNT   = 16;

    typedef struct packed {
        logic [RMS_BITS-1:0] level;
        logic [RMS_BITS-1:0] block_rms;
        logic [RMS_BITS-1:0] noise_floor;
    } t_rms_report;

    typedef struct packed {
        bit                  set_len;
        logic [CNT_BITS-1:0] len;
        logic [15:0]         smp;
        bit                  typed;
        t_rms_report         want;
    } t_probe_row;

    typedef enum int {
        MIX_FULL,
        MIX_QUIET,
        MIX_EDGE,
        MIX_SCALED,
        MIX_BLEND
    } t_sample_mix;

    // Rows with a typed result can be checked by hand; the others go through the predictor.
    localparam t_probe_row PROBE_ROWS [PROBE_COUNT] = '{
        '{1'b1, 16'd1,     16'h8000, 1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b0, 16'd0,     16'h7FFF, 1'b1, '{16'd0,     16'd32767, 16'd32767}},
        '{1'b0, 16'd0,     16'h0001, 1'b1, '{16'd0,     16'd1,     16'd1}},
        '{1'b0, 16'd0,     16'hFFFF, 1'b1, '{16'd0,     16'd1,     16'd1}},
        '{1'b1, 16'd0,     16'h5555, 1'b1, '{16'd21844, 16'd21845, 16'd1}},
        '{1'b0, 16'd0,     16'hAAAA, 1'b1, '{16'd21845, 16'd21846, 16'd1}},
        '{1'b1, 16'd2,     16'd3,    1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b0, 16'd0,     16'd4,    1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b1, 16'd4,     16'd300,  1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b0, 16'd0,     16'hFED4, 1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b0, 16'd0,     16'd300,  1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b1, 16'd2,     16'hFED4, 1'b1, '{16'd299,   16'd300,   16'd1}},
        '{1'b1, 16'd3,     16'h7FFF, 1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b0, 16'd0,     16'h8000, 1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b0, 16'd0,     16'h0000, 1'b0, '{16'd0,     16'd0,     16'd0}},
        '{1'b1, 16'd65535, 16'h0007, 1'b0, '{16'd0,     16'd0,     16'd0}}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [15:0] i_sample    = '0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [15:0] o_level;
    logic [15:0] o_block_rms;
    logic [15:0] o_noise_floor;
    logic        i_cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    // Predictor state.
    logic [63:0]         sq_acc;
    int unsigned         taken;
    logic [MIN_BITS-1:0] floor_min;
    logic [CNT_BITS-1:0] len_reg;

    t_rms_report rms_expected_q[$];
    bit          no_stall   = 1'b0;
    int          mismatches = 0;
    int unsigned cycles     = 0;

    rms_level_floor_tracker_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .empty        (empty),
        .pop          (pop),
        .o_level      (o_level),
        .o_block_rms  (o_block_rms),
        .o_noise_floor(o_noise_floor),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= v) r = t;
        end
        return r;
    endfunction

    task automatic track_sample(input logic [15:0] smp, output bit done,
                                output t_rms_report rep);
        logic signed [16:0] sv;
        logic [16:0]        mag;
        logic [31:0]        root;
        int unsigned        span;
        sv   = 17'($signed(smp));
        mag  = sv[16] ? 17'(-sv) : 17'(sv);
        sq_acc += 64'(mag) * 64'(mag);
        taken++;
        span = (len_reg == 0) ? 1 : len_reg;
        done = 1'b0;
        rep  = '0;
        if (taken >= span) begin
            root = floor_root(sq_acc / 64'(taken));
            if (root > 32'hFFFF) root = 32'hFFFF;
            if (17'(root) < floor_min) floor_min = 17'(root);
            rep.block_rms   = root[15:0];
            rep.noise_floor = floor_min[15:0];
            rep.level       = root[15:0] - floor_min[15:0];
            sq_acc = '0;
            taken  = 0;
            done   = 1'b1;
        end
    endtask

    task automatic feed_sample(input logic [15:0] smp, input bit typed,
                               input t_rms_report want);
        int          gap;
        bit          done;
        t_rms_report rep;
        gap = no_stall ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        track_sample(smp, done, rep);
        if (done) rms_expected_q.push_back(typed ? want : rep);
    endtask

    // The block must be idle: every result out and the accumulator settled.
    task automatic write_block_length(input logic [CNT_BITS-1:0] len);
        push <= 1'b0;
        while (rms_expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        len_reg = len;
    endtask

    function automatic logic [15:0] draw_sample(input t_sample_mix mix);
        logic [15:0] raw;
        raw = 16'($urandom);
        if (mix == MIX_BLEND) mix = t_sample_mix'($urandom_range(0, 3));
        case (mix)
            MIX_FULL: return raw;
            MIX_QUIET: return 16'($urandom_range(0, 31)) - 16'd16;
            MIX_EDGE: begin
                case ($urandom_range(0, 4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            default: return 16'($signed(raw) >>> $urandom_range(0, 14));
        endcase
    endfunction

    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_stall ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_rms_report want;
        if (i_rst_n && pop && !empty) begin
            if (rms_expected_q.size() == 0) begin
                $error("unexpected result: level %0d block_rms %0d noise_floor %0d",
                       o_level, o_block_rms, o_noise_floor);
                mismatches++;
            end else begin
                want = rms_expected_q.pop_front();
                if (o_level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, o_level);
                    mismatches++;
                end
                if (o_block_rms !== want.block_rms) begin
                    $error("block_rms: expected %0d, got %0d", want.block_rms, o_block_rms);
                    mismatches++;
                end
                if (o_noise_floor !== want.noise_floor) begin
                    $error("noise_floor: expected %0d, got %0d", want.noise_floor,
                           o_noise_floor);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int          fed;
        int          n;
        int          pick;
        int unsigned blk;
        int unsigned span;
        t_sample_mix mix;
        t_probe_row  row;
        sq_acc    = '0;
        taken     = 0;
        floor_min = MIN_RMS_NONE;
        len_reg   = BLOCK_LENGTH_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Part of a block at the length left by reset, sent back to back; no
        // result may come out, and the next length change ends the block early.
        no_stall = 1'b1;
        repeat (PREFIX_ITEMS) feed_sample(16'h7FFF, 1'b0, '0);
        no_stall = 1'b0;

        for (int k = 0; k < PROBE_COUNT; k++) begin
            row = PROBE_ROWS[k];
            if (row.set_len) write_block_length(row.len);
            feed_sample(row.smp, row.typed, row.want);
        end

        // Leftover samples from one phase carry into the next block length, so
        // lowering the length mid-block comes up often.
        fed = 0;
        while (fed < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) blk = 0;
            else if (pick <= 11) blk = $urandom_range(1, 4);
            else if (pick <= 16) blk = $urandom_range(5, 32);
            else if (pick <= 18) blk = $urandom_range(33, 300);
            else blk = 65535;
            span = (blk == 0) ? 1 : blk;
            if (blk == 65535) n = $urandom_range(1, 20);
            else if (span > 32) n = span + $urandom_range(0, span - 1);
            else n = span * $urandom_range(1, 4) + $urandom_range(0, span - 1);
            write_block_length(blk[15:0]);
            no_stall = ($urandom_range(0, 4) == 0);
            mix = t_sample_mix'($urandom_range(0, 4));
            repeat (n) feed_sample(draw_sample(mix), 1'b0, '0);
            fed += n;
        end
        no_stall = 1'b0;
        push <= 1'b0;

        while (rms_expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
